/* design/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 byte stream decoder.
package utf8d_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_CHAR      = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_END       = 2'd3
    } status_t;

    // Byte classification masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // Code points in text mode never exceed 21 bits
    localparam int unsigned CP_BITS = 21;

    // Input transaction held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } in_item_t;

    // One decode result handed to the output register
    typedef struct packed {
        logic        valid;
        logic [31:0] code_point;
        status_t     status;
        logic [31:0] chars_decoded;
    } dec_result_t;

    // Decoder state visible to the top level
    typedef struct packed {
        logic [1:0] bytes_pending;
        logic       binary_mode;
    } dec_state_t;

endpackage

/* design/utf8d_in_stage.sv */
// Input register stage: captures one byte transaction per cycle while in_ready is high.
module utf8d_in_stage
    import utf8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // Accept when empty or when the held transaction moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* design/utf8d_decode.sv */
// Decoder: sequence state, mode register, character count and per-byte decode.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        fire,
    input  in_item_t    item,
    output dec_result_t result,
    output dec_state_t  state
);

    logic [1:0]  pending_reg,  pending_next;
    logic [31:0] partial_reg,  partial_next;
    logic [31:0] count_reg,    count_next;
    logic        mode_reg;

    logic        emit;
    status_t     st;
    logic [31:0] value;
    logic [7:0]  b;
    logic [31:0] cont_value;

    assign b          = item.data_byte;
    assign cont_value = {11'd0, partial_reg[CP_BITS-7:0], b[5:0]};

    // Decode one transaction
    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        st           = STATUS_CHAR;
        value        = 32'd0;
        if (item.is_end)
        begin
            emit         = 1'b1;
            st           = (pending_reg != 2'd0) ? STATUS_TRUNCATED : STATUS_END;
            pending_next = 2'd0;
            partial_next = 32'd0;
        end
        else if (mode_reg)
        begin
            // Assemble big-endian word
            if (pending_reg == 2'd3)
            begin
                emit         = 1'b1;
                value        = {partial_reg[23:0], b};
                pending_next = 2'd0;
                partial_next = 32'd0;
            end
            else
            begin
                partial_next = {partial_reg[23:0], b};
                pending_next = pending_reg + 2'd1;
            end
        end
        else if (pending_reg == 2'd0)
        begin
            // Lead byte
            if (!b[7])
            begin
                emit  = 1'b1;
                value = {24'd0, b};
            end
            else if ((b & LEAD2_MASK) == LEAD2_PAT)
            begin
                partial_next = {27'd0, b[4:0]};
                pending_next = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_PAT)
            begin
                partial_next = {28'd0, b[3:0]};
                pending_next = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_PAT)
            begin
                partial_next = {29'd0, b[2:0]};
                pending_next = 2'd3;
            end
            else
            begin
                emit = 1'b1;
                st   = STATUS_MALFORMED;
            end
        end
        else if ((b & CONT_MASK) != CONT_PAT)
        begin
            // Drop the open sequence on a bad continuation
            emit         = 1'b1;
            st           = STATUS_MALFORMED;
            pending_next = 2'd0;
            partial_next = 32'd0;
        end
        else if (pending_reg == 2'd1)
        begin
            emit         = 1'b1;
            value        = cont_value;
            pending_next = 2'd0;
            partial_next = 32'd0;
        end
        else
        begin
            partial_next = cont_value;
            pending_next = pending_reg - 2'd1;
        end
        count_next = (emit && st == STATUS_CHAR) ? count_reg + 32'd1 : count_reg;
    end

    assign result.valid         = fire && emit;
    assign result.code_point    = value;
    assign result.status        = st;
    assign result.chars_decoded = count_next;

    assign state.bytes_pending = pending_reg;
    assign state.binary_mode   = mode_reg;

    // Update state on a mode write or a decoded transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            pending_reg <= 2'd0;
            partial_reg <= 32'd0;
            count_reg   <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg    <= cfg_wr_data;
            pending_reg <= 2'd0;
            partial_reg <= 32'd0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

endmodule

/* design/utf8d_out_stage.sv */
// Output register stage: holds one result transaction until taken.
module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dec_result_t result,
    output logic        advance,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] code_point,
    output logic [1:0]  status,
    output logic [31:0] chars_decoded
);

    logic        valid_reg;
    logic [31:0] code_point_reg;
    status_t     status_reg;
    logic [31:0] count_reg;

    // Move on when the register is empty or being drained
    assign advance       = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign code_point    = code_point_reg;
    assign status        = status_reg;
    assign chars_decoded = count_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= result.valid;
        end
    end

    // Load payload
    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            code_point_reg <= result.code_point;
            status_reg     <= result.status;
            count_reg      <= result.chars_decoded;
        end
    end

endmodule

/* design/utf8_byte_stream_decoder_core.sv */
// Top level of the UTF-8 / big-endian word byte stream decoder.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | in_valid / in_ready    | data_byte[7:0], is_end
//   output   | out_valid / out_ready  | code_point[31:0], status[1:0],
//            |                        | chars_decoded[31:0]
//   config   | cfg_wr_en              | cfg_wr_data (binary_mode)
//
// One byte transaction per cycle sustained while out_ready is high; a result is
// decoded from the input register into the output register and is shown on
// the outputs from there. The decode step updates the sequence state for each
// byte. Reset clears the mode to text, the open sequence and the count.
// A stall on out_ready holds the output register, then the input register,
// and in_ready drops once both are full.
module utf8_byte_stream_decoder_core
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] code_point,
    output logic [1:0]  status,
    output logic [31:0] chars_decoded
);

    in_item_t    in_item;
    in_item_t    item;
    logic        item_valid;
    logic        advance;
    logic        fire;
    dec_result_t result;
    dec_state_t  state;

    assign in_item.data_byte = data_byte;
    assign in_item.is_end    = is_end;
    assign fire              = item_valid && advance;

    // Input register
    utf8d_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode step and sequence state
    utf8d_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .result      (result),
        .state       (state)
    );

    // Output register
    utf8d_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .result        (result),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .status        (status),
        .chars_decoded (chars_decoded)
    );

`ifndef ASSERT_OFF
    // Non-character results carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_CHAR |-> code_point == 32'd0)
        else $error("non-character result with nonzero code point");

    // An end transaction always closes the open sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.is_end && !cfg_wr_en |=> state.bytes_pending == 2'd0)
        else $error("sequence still open after end marker");

    // A mode write drops any open sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> state.bytes_pending == 2'd0)
        else $error("sequence still open after mode write");

    // Text-mode characters fit in 21 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == STATUS_CHAR && !state.binary_mode
        |-> result.code_point[31:CP_BITS] == '0)
        else $error("text-mode code point exceeds 21 bits");
`endif

endmodule

/* sim/tb.sv */
// Testbench for the UTF-8 / big-endian word byte stream decoder core.
module tb;
    import utf8d_pkg::*;

    localparam int          HALF_PERIOD     = 5;
    localparam int          RESET_CYCLES    = 10;
    localparam int          RANDOM_ITEMS    = 1600;
    localparam int          PHASES          = 8;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          WATCHDOG_CYCLES = 2000;
    localparam int          MAX_GAP         = 16;
    localparam logic [31:0] CP_LIMIT        = (32'd1 << CP_BITS) - 1;

    // One decoded result as it leaves the block
    typedef struct packed {
        logic [31:0] code_point;
        status_t     status;
        logic [31:0] chars_decoded;
    } decoded_t;

    // One directed byte; known rows carry a hand-written result
    typedef struct packed {
        logic        mode;
        logic        last;
        logic [7:0]  value;
        logic        known;
        logic [31:0] want_cp;
        status_t     want_st;
    } probe_t;

    localparam probe_t DIRECTED [32] = '{
        '{1'b0, 1'b0, 8'h00, 1'b1, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h7F, 1'b1, 32'h0000_007F, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h80, 1'b1, 32'h0000_0000, STATUS_MALFORMED},
        '{1'b0, 1'b0, 8'hF8, 1'b1, 32'h0000_0000, STATUS_MALFORMED},
        '{1'b0, 1'b0, 8'hFF, 1'b1, 32'h0000_0000, STATUS_MALFORMED},
        '{1'b0, 1'b0, 8'hC2, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hA9, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hE2, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h82, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hAC, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hF7, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hBF, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hBF, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hBF, 1'b1, 32'h001F_FFFF, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hC0, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h80, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'hE0, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h41, 1'b1, 32'h0000_0000, STATUS_MALFORMED},
        '{1'b0, 1'b0, 8'hF0, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h90, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b1, 8'h00, 1'b1, 32'h0000_0000, STATUS_TRUNCATED},
        '{1'b0, 1'b1, 8'hFF, 1'b1, 32'h0000_0000, STATUS_END},
        '{1'b0, 1'b0, 8'hE2, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b0, 1'b0, 8'h82, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b1, 1'b0, 8'hFF, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b1, 1'b0, 8'hFF, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b1, 1'b0, 8'hFF, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b1, 1'b0, 8'hFF, 1'b1, 32'hFFFF_FFFF, STATUS_CHAR},
        '{1'b1, 1'b0, 8'h12, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b1, 1'b0, 8'h34, 1'b0, 32'h0000_0000, STATUS_CHAR},
        '{1'b1, 1'b1, 8'h00, 1'b1, 32'h0000_0000, STATUS_TRUNCATED},
        '{1'b1, 1'b0, 8'hAB, 1'b0, 32'h0000_0000, STATUS_CHAR}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        is_end;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] code_point;
    logic [1:0]  status;
    logic [31:0] chars_decoded;

    // Side band that travels with the directed payload
    logic        note_known;
    logic [31:0] note_cp;
    status_t     note_st;

    // Predictor state
    logic        word_mode;
    logic [1:0]  pending_bytes;
    logic [31:0] assembled;
    logic [31:0] good_chars;
    decoded_t    decoded_queue [$];

    int          errors      = 0;
    int          idle_cycles = 0;
    int          bytes_sent  = 0;
    bit          in_steady   = 1'b0;
    bit          out_steady  = 1'b0;

    utf8_byte_stream_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .is_end        (is_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .status        (status),
        .chars_decoded (chars_decoded)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Draw a wait; now and then switch between busy and quiet stretches
    function automatic int pick_gap(inout bit steady);
        if ($urandom_range(0, 63) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Advance the decoder state by one byte or end marker
    function automatic void decode_byte(input logic [7:0] b, input logic last,
                                        output bit emits, output decoded_t res);
        logic [31:0] val;
        status_t     st;
        emits = 1'b0;
        val   = '0;
        st    = STATUS_CHAR;
        if (last)
        begin
            emits         = 1'b1;
            st            = (pending_bytes != 2'd0) ? STATUS_TRUNCATED : STATUS_END;
            pending_bytes = '0;
            assembled     = '0;
        end
        else if (word_mode)
        begin
            assembled = {assembled[23:0], b};
            if (pending_bytes == 2'd3)
            begin
                emits         = 1'b1;
                val           = assembled;
                pending_bytes = '0;
                assembled     = '0;
            end
            else
                pending_bytes = pending_bytes + 2'd1;
        end
        else if (pending_bytes == 2'd0)
        begin
            if (b < CONT_PAT)
            begin
                emits = 1'b1;
                val   = {24'd0, b};
            end
            else if ((b & LEAD2_MASK) == LEAD2_PAT)
            begin
                assembled     = {24'd0, b & ~LEAD2_MASK};
                pending_bytes = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_PAT)
            begin
                assembled     = {24'd0, b & ~LEAD3_MASK};
                pending_bytes = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_PAT)
            begin
                assembled     = {24'd0, b & ~LEAD4_MASK};
                pending_bytes = 2'd3;
            end
            else
            begin
                emits = 1'b1;
                st    = STATUS_MALFORMED;
            end
        end
        else if ((b & CONT_MASK) != CONT_PAT)
        begin
            // Drop the open sequence along with the bad byte
            emits         = 1'b1;
            st            = STATUS_MALFORMED;
            pending_bytes = '0;
            assembled     = '0;
        end
        else
        begin
            assembled     = ((assembled << 6) | {24'd0, b & ~CONT_MASK}) & CP_LIMIT;
            pending_bytes = pending_bytes - 2'd1;
            if (pending_bytes == 2'd0)
            begin
                emits     = 1'b1;
                val       = assembled;
                assembled = '0;
            end
        end
        if (emits && st == STATUS_CHAR)
            good_chars = good_chars + 32'd1;
        res.code_point    = val;
        res.status        = st;
        res.chars_decoded = good_chars;
    endfunction

    // Track config writes and transactions, check results, run the watchdog
    always @(posedge clk)
    begin
        decoded_t want;
        decoded_t got;
        bit       emits;
        if (!rst_n)
        begin
            word_mode     = 1'b0;
            pending_bytes = '0;
            assembled     = '0;
            good_chars    = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.code_point    = code_point;
                got.status        = status_t'(status);
                got.chars_decoded = chars_decoded;
                if (decoded_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, %s %h %0d %0d",
                             $time, "got cp/status/count",
                             got.code_point, got.status, got.chars_decoded);
                end
                else
                begin
                    want = decoded_queue.pop_front();
                    if (got.code_point !== want.code_point)
                    begin
                        errors++;
                        $display("%0t: code_point expected %h got %h",
                                 $time, want.code_point, got.code_point);
                    end
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.chars_decoded !== want.chars_decoded)
                    begin
                        errors++;
                        $display("%0t: chars_decoded expected %0d got %0d",
                                 $time, want.chars_decoded, got.chars_decoded);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                word_mode     = cfg_wr_data;
                pending_bytes = '0;
                assembled     = '0;
            end
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, is_end, emits, want);
                if (note_known)
                begin
                    want.code_point = note_cp;
                    want.status     = note_st;
                    emits           = 1'b1;
                end
                if (emits)
                    decoded_queue = {decoded_queue, want};
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Stall the result side at random, one draw per result
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(out_steady);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Offer one byte transaction after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = pick_gap(in_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        is_end    <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Encode a code point in len bytes and send the first keep of them
    task automatic send_text(input int len, input logic [20:0] cp, input int keep);
        logic [7:0] seq [4];
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            send_byte(seq[i], 1'b0);
    endtask

    // Hold input low until every result is out and the pipeline has emptied
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the mode register while the block is idle
    task automatic set_mode(input logic mode);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic        mode_now;
        logic [20:0] cp;
        logic [7:0]  junk;
        int          pick;
        int          len;
        int          phase_goal;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= '0;
        is_end      <= 1'b0;
        note_known  <= 1'b0;
        note_cp     <= '0;
        note_st     <= STATUS_CHAR;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, switching mode where the rows ask for it
        mode_now = 1'b0;
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].mode != mode_now)
            begin
                mode_now = DIRECTED[i].mode;
                set_mode(mode_now);
            end
            note_known <= DIRECTED[i].known;
            note_cp    <= DIRECTED[i].want_cp;
            note_st    <= DIRECTED[i].want_st;
            send_byte(DIRECTED[i].value, DIRECTED[i].last);
        end
        note_known <= 1'b0;

        // Random phases; each mode write also drops whatever is left open
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 2)
                mode_now = phase[0];
            else
                mode_now = ($urandom_range(0, 2) == 0);
            set_mode(mode_now);
            phase_goal = bytes_sent + RANDOM_ITEMS / PHASES;
            while (bytes_sent < phase_goal)
            begin
                pick = $urandom_range(0, 99);
                cp   = 21'($urandom);
                if (mode_now)
                    send_byte(8'($urandom), pick < 4);
                else if (pick < 65)
                begin
                    len = $urandom_range(1, 4);
                    send_text(len, cp, len);
                end
                else if (pick < 88)
                begin
                    // Broken sequence: cut short by a bad byte or an end marker
                    len = $urandom_range(2, 4);
                    send_text(len, cp, $urandom_range(1, len - 1));
                    if (pick < 78)
                    begin
                        do
                            junk = 8'($urandom);
                        while ((junk & CONT_MASK) == CONT_PAT);
                        send_byte(junk, 1'b0);
                    end
                    else
                        send_byte(8'($urandom), 1'b1);
                end
                else if (pick < 96)
                    send_byte(8'($urandom), 1'b0);
                else
                    send_byte(8'($urandom), 1'b1);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && decoded_queue.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
design/utf8d_pkg.sv
design/utf8d_in_stage.sv
design/utf8d_decode.sv
design/utf8d_out_stage.sv
design/utf8_byte_stream_decoder_core.sv
sim/tb.sv
